FILE: design/assert_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define HDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// consequent that must hold in the clock cycle after the antecedent
`define HDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define HDC_ASSERT(label, clk, rst_n, prop)
`define HDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/hdc_pkg.sv
// types and constants of the header/id/checksum deframer
// no dependencies; used by the interfaces and the top level
package hdc_pkg;

    localparam logic [7:0] HDR_BYTE        = 8'hFF;
    localparam logic [7:0] DEVICE_ID_RESET = 8'h01;
    localparam logic [7:0] MIN_LENGTH      = 8'd2;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_BODY = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

endpackage

FILE: design/hdc_if.sv
// valid/ready channels of the deframer: received bytes in, results out
// depends on hdc_pkg
interface hdc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hdc_res_if;
    import hdc_pkg::*;
    logic       valid;
    logic       ready;
    t_kind      out_kind;
    logic [7:0] out_byte;
    logic [7:0] out_index;

    modport source (output valid, output out_kind, output out_byte, output out_index,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_index,
                    output ready);
endinterface

FILE: design/header_id_checksum_deframer.sv
// top level of the header/id/checksum deframer
// depends on hdc_pkg, hdc_if.sv and assert_macros.svh
`include "assert_macros.svh"

// Byte deframer for streams of the form FF FF id length body... checksum.
// One received beat is taken every clock cycle while the result stage is
// not stalled; a beat passes through the input register and then the result
// register. The byte state machine between those two registers decides each
// byte in a single pass. When the result register holds a beat the sink has
// not taken, both stages hold; i_rx.ready stays high while the input
// register is empty, so one more byte is taken, and then drops until the
// sink takes the result. Header, id and length bytes give no result. Each
// body byte gives a body beat with its position; the checksum byte gives one
// good or bad beat carrying the length byte, then hunting starts again.
// Frames with a foreign id, a broken second header byte or a length below
// two are dropped without any result. The user must write device_id through
// i_cfg_we/i_cfg_data only while the block is idle; the block itself does
// not enforce this.
module header_id_checksum_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    hdc_rx_if.sink     i_rx,
    hdc_res_if.source  o_res
);
    import hdc_pkg::*;

    // configuration
    logic [7:0] r_device_id;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // frame state
    t_phase     r_phase,   n_phase;
    logic [7:0] r_sum,     n_sum;
    logic [7:0] r_len,     n_len;
    logic [7:0] r_count,   n_count;

    // result register
    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_byte;
    logic [7:0] r_out_index;

    // result of the current byte
    logic       n_res_valid;
    t_kind      n_kind;
    logic [7:0] n_byte;
    logic [7:0] n_index;

    logic       w_advance;   // second stage moves this cycle
    logic       w_fire;      // a byte is decided this cycle
    logic       w_more_body; // byte is a body byte, not the checksum
    logic [7:0] w_count_inc;

    assign w_advance   = !r_out_valid || o_res.ready;
    assign w_fire      = r_in_valid && w_advance;
    assign i_rx.ready  = !r_in_valid || w_advance;
    assign w_count_inc = r_count + 8'd1;
    // body_count + 1 < length, compared without wrap since count < length
    assign w_more_body = ({1'b0, r_count} + 9'd1) < {1'b0, r_len};

    // next frame state for the byte in the input register
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_len   = r_len;
        n_count = r_count;
        unique case (r_phase)
            PH_HDR1: begin
                n_phase = (r_in_byte == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
            end
            PH_HDR2: begin
                // a broken second header byte is not retried as a first one
                n_phase = (r_in_byte == HDR_BYTE) ? PH_ID : PH_HDR1;
            end
            PH_ID: begin
                if (r_in_byte == r_device_id) begin
                    n_sum   = r_in_byte;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_LEN: begin
                if (r_in_byte < MIN_LENGTH) begin
                    n_phase = PH_HDR1;
                end else begin
                    n_len   = r_in_byte;
                    n_sum   = r_sum + r_in_byte;
                    n_count = 8'd0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (w_more_body) begin
                    n_sum   = r_sum + r_in_byte;
                    n_count = w_count_inc;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            default: begin
                // unreachable codes behave like hunting the first header byte
                n_phase = (r_in_byte == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
            end
        endcase
    end

    // result beat for the byte in the input register
    always_comb begin
        n_res_valid = 1'b0;
        n_kind      = KIND_BODY;
        n_byte      = r_in_byte;
        n_index     = r_count;
        if (r_phase == PH_BODY) begin
            n_res_valid = 1'b1;
            if (!w_more_body) begin
                // checksum byte: inverted sum of id, length and body
                n_kind  = (r_in_byte == ~r_sum) ? KIND_GOOD : KIND_BAD;
                n_byte  = r_len;
                n_index = 8'd0;
            end
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= DEVICE_ID_RESET;
        end else if (i_cfg_we) begin
            r_device_id <= i_cfg_data;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // frame state and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR1;
            r_sum       <= 8'd0;
            r_len       <= 8'd0;
            r_count     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_len   <= n_len;
                r_count <= n_count;
            end
            if (w_advance) begin
                r_out_valid <= w_fire && n_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_res_valid) begin
            r_out_kind  <= n_kind;
            r_out_byte  <= n_byte;
            r_out_index <= n_index;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_kind  = r_out_kind;
    assign o_res.out_byte  = r_out_byte;
    assign o_res.out_index = r_out_index;

    // checks
    `HDC_ASSERT(a_body_len_ok, i_clk, i_rst_n, (r_phase != PH_BODY) || (r_len >= MIN_LENGTH))
    `HDC_ASSERT(a_body_index_in_frame, i_clk, i_rst_n,
        !(r_out_valid && (r_out_kind == KIND_BODY)) ||
        (({1'b0, r_out_index} + 9'd1) < {1'b0, r_len}))
    `HDC_ASSERT(a_end_index_zero, i_clk, i_rst_n,
        !(r_out_valid && (r_out_kind != KIND_BODY)) || (r_out_index == 8'd0))
    `HDC_ASSERT_NEXT(a_end_rehunts, i_clk, i_rst_n,
        w_fire && n_res_valid && (n_kind != KIND_BODY), r_phase == PH_HDR1)
    `HDC_ASSERT_NEXT(a_stall_holds_state, i_clk, i_rst_n,
        !w_advance && !i_cfg_we, $stable(r_phase) && $stable(r_sum))

endmodule
